/* design/lhfc_pkg.sv */
// Shared constants and types for the level to HSV false color block.
`timescale 1ns / 1ps

package lhfc_pkg;

  // Width of pixel levels and of the min/max registers.
  localparam int LEVEL_BITS  = 16;
  // Fraction bits of the scaled hue (hue / 60 in 3.16 format).
  localparam int FRAC_BITS   = 16;
  // Dividend shift: 4 sectors times 2^FRAC_BITS.
  localparam int HUE_SHIFT   = FRAC_BITS + 2;
  localparam int QUO_BITS    = HUE_SHIFT + 1;
  localparam int DIV_STAGES  = QUO_BITS;
  localparam int SECTOR_BITS = QUO_BITS - FRAC_BITS;
  localparam int CHAN_BITS   = 8;
  localparam int PROD_BITS   = FRAC_BITS + CHAN_BITS;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CHAN_BITS-1:0] CH_V = CHAN_BITS'(127);
  localparam logic [CHAN_BITS-1:0] CH_P = CHAN_BITS'(25);
  localparam logic [PROD_BITS-1:0] Q_BASE  = PROD_BITS'(8355840);
  localparam logic [PROD_BITS-1:0] T_BASE  = PROD_BITS'(1671168);
  localparam logic [PROD_BITS-1:0] F_SLOPE = PROD_BITS'(102);

  localparam logic [LEVEL_BITS-1:0] MIN_RESET = '0;
  localparam logic [LEVEL_BITS-1:0] MAX_RESET = LEVEL_BITS'(65535);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_LEVEL = 1'b0,
    REG_MAX_LEVEL = 1'b1
  } cfg_reg_t;

  typedef enum logic [SECTOR_BITS-1:0] {
    SEC_RED_YELLOW  = 3'd0,
    SEC_YELLOW_GRN  = 3'd1,
    SEC_GRN_CYAN    = 3'd2,
    SEC_CYAN_BLUE   = 3'd3,
    SEC_BLUE        = 3'd4
  } sector_t;

  // Word leaving the divider: valid bit and the scaled hue.
  typedef struct packed {
    logic                valid;
    logic [QUO_BITS-1:0] quo;
  } div_out_t;

endpackage

/* design/lhfc_div.sv */
// Pipelined restoring divider: one quotient bit per stage, bubbles collapse.
`timescale 1ns / 1ps

module lhfc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lhfc_pkg::LEVEL_BITS-1:0]     num,
  input  logic [lhfc_pkg::LEVEL_BITS-1:0]     den,
  input  logic                                take,
  output lhfc_pkg::div_out_t                  result
);

  localparam int LB = lhfc_pkg::LEVEL_BITS;
  localparam int QB = lhfc_pkg::QUO_BITS;
  localparam int NS = lhfc_pkg::DIV_STAGES;

  logic          valid_q [NS];
  logic          adv     [NS];
  logic [LB-1:0] rem_q   [NS];
  logic [LB-1:0] den_q   [NS];
  logic [QB-1:0] quo_q   [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic          valid_in;
    logic [LB-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [LB:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      // num never exceeds den, so the top quotient bit is num >= den
      assign valid_in = in_valid;
      assign den_in   = den;
      assign quo_in   = '0;
      assign trial    = {1'b0, num};
    end else begin : g_next
      assign valid_in = valid_q[j-1];
      assign den_in   = den_q[j-1];
      assign quo_in   = quo_q[j-1];
      assign trial    = {rem_q[j-1], 1'b0};
    end

    if (j == NS - 1) begin : g_last_adv
      assign adv[j] = !valid_q[j] || take;
    end else begin : g_mid_adv
      assign adv[j] = !valid_q[j] || adv[j+1];
    end

    assign ge = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[j] <= 1'b0;
      end else if (adv[j]) begin
        valid_q[j] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rem_q[j] <= ge ? LB'(trial - {1'b0, den_in}) : trial[LB-1:0];
        den_q[j] <= den_in;
        quo_q[j] <= {quo_in[QB-2:0], ge};
      end
    end
  end

  assign in_ready     = adv[0];
  assign result.valid = valid_q[NS-1];
  assign result.quo   = quo_q[NS-1];

endmodule

/* design/level_to_hsv_false_color.sv */
// Top level: pixel level to false color RGB through a pipelined hue divider.
`timescale 1ns / 1ps

// One pixel level in, one RGB triple out, at a sustained rate of one word per
// clock while the output is not stalled. The pipe is a clamp/offset stage, a
// 19-stage restoring divider producing one quotient bit per stage, a
// multiply stage and the output register. Empty stages close up under output
// stall, so the input keeps taking words until the whole pipe is full.
// min_level and max_level are sampled at the input; write them only while
// the pipe is empty. A range with max_level at or below min_level gives
// (127, 25, 25) for every pixel.
module level_to_hsv_false_color (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [lhfc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [lhfc_pkg::LEVEL_BITS-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [lhfc_pkg::LEVEL_BITS-1:0]         pixel_level,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [lhfc_pkg::CHAN_BITS-1:0]          red,
  output logic [lhfc_pkg::CHAN_BITS-1:0]          green,
  output logic [lhfc_pkg::CHAN_BITS-1:0]          blue
);

  localparam int LB = lhfc_pkg::LEVEL_BITS;
  localparam int FB = lhfc_pkg::FRAC_BITS;
  localparam int PB = lhfc_pkg::PROD_BITS;
  localparam int CB = lhfc_pkg::CHAN_BITS;
  localparam int SB = lhfc_pkg::SECTOR_BITS;
  localparam int QB = lhfc_pkg::QUO_BITS;

  logic [LB-1:0] min_level;
  logic [LB-1:0] max_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= lhfc_pkg::MIN_RESET;
      max_level <= lhfc_pkg::MAX_RESET;
    end else if (cfg_we) begin
      unique case (lhfc_pkg::cfg_reg_t'(cfg_index))
        lhfc_pkg::REG_MIN_LEVEL: min_level <= cfg_data;
        lhfc_pkg::REG_MAX_LEVEL: max_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance enables, from the output back to the input.
  logic adv_out, adv_mul, adv_prep, div_ready;
  lhfc_pkg::div_out_t div_res;

  logic          prep_valid;
  logic [LB-1:0] prep_num;
  logic [LB-1:0] prep_den;
  logic          mul_valid;
  logic [SB-1:0] mul_sector;
  logic [PB-1:0] mul_prod;

  assign adv_out  = !out_valid || !out_stall;
  assign adv_mul  = !mul_valid || adv_out;
  assign adv_prep = !prep_valid || div_ready;
  assign in_stall = !adv_prep;

  // Clamp and offset; an empty range divides 0 by 1.
  logic          range_empty;
  logic [LB-1:0] level_clamped;

  always_comb begin
    range_empty = max_level <= min_level;
    if (pixel_level < min_level) begin
      level_clamped = min_level;
    end else if (pixel_level > max_level) begin
      level_clamped = max_level;
    end else begin
      level_clamped = pixel_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (adv_prep) begin
      prep_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_prep) begin
      prep_num <= range_empty ? '0 : level_clamped - min_level;
      prep_den <= range_empty ? LB'(1) : max_level - min_level;
    end
  end

  lhfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (prep_valid),
    .in_ready (div_ready),
    .num      (prep_num),
    .den      (prep_den),
    .take     (adv_mul),
    .result   (div_res)
  );

  // Slope term 102 * f.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (adv_mul) begin
      mul_valid <= div_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_mul) begin
      mul_sector <= div_res.quo[QB-1:FB];
      mul_prod   <= PB'(div_res.quo[FB-1:0]) * lhfc_pkg::F_SLOPE;
    end
  end

  // Falling and rising ramps, then sector select.
  logic [PB-1:0] q_full;
  logic [PB-1:0] t_full;
  logic [CB-1:0] q_chan;
  logic [CB-1:0] t_chan;
  logic [CB-1:0] red_next;
  logic [CB-1:0] green_next;
  logic [CB-1:0] blue_next;

  always_comb begin
    q_full = lhfc_pkg::Q_BASE - mul_prod;
    t_full = lhfc_pkg::T_BASE + mul_prod;
    q_chan = q_full[PB-1:FB];
    t_chan = t_full[PB-1:FB];
    unique case (lhfc_pkg::sector_t'(mul_sector))
      lhfc_pkg::SEC_RED_YELLOW: begin
        red_next = lhfc_pkg::CH_V; green_next = t_chan;         blue_next = lhfc_pkg::CH_P;
      end
      lhfc_pkg::SEC_YELLOW_GRN: begin
        red_next = q_chan;         green_next = lhfc_pkg::CH_V; blue_next = lhfc_pkg::CH_P;
      end
      lhfc_pkg::SEC_GRN_CYAN: begin
        red_next = lhfc_pkg::CH_P; green_next = lhfc_pkg::CH_V; blue_next = t_chan;
      end
      lhfc_pkg::SEC_CYAN_BLUE: begin
        red_next = lhfc_pkg::CH_P; green_next = q_chan;         blue_next = lhfc_pkg::CH_V;
      end
      default: begin
        red_next = t_chan;         green_next = lhfc_pkg::CH_P; blue_next = lhfc_pkg::CH_V;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

/* design/lhfc_checker.sv */
// Port-level checker for the false color block, bound to the top level.
`timescale 1ns / 1ps

module lhfc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [lhfc_pkg::CHAN_BITS-1:0]     red,
  input logic [lhfc_pkg::CHAN_BITS-1:0]     green,
  input logic [lhfc_pkg::CHAN_BITS-1:0]     blue
);

  // A held word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("output word changed while stalled");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Every sector carries the full value channel.
  a_has_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == lhfc_pkg::CH_V || green == lhfc_pkg::CH_V ||
                   blue == lhfc_pkg::CH_V))
    else $error("no channel at full value");

  // Every sector carries the floor channel.
  a_has_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == lhfc_pkg::CH_P || green == lhfc_pkg::CH_P ||
                   blue == lhfc_pkg::CH_P))
    else $error("no channel at floor value");

endmodule

bind level_to_hsv_false_color lhfc_checker u_lhfc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .red       (red),
  .green     (green),
  .blue      (blue)
);

/* tb/sv/tb_level_to_hsv_false_color.sv */
// Testbench for the level to HSV false color block: range setups, idling, color check.
`timescale 1ns / 1ps

module tb_level_to_hsv_false_color;
  import lhfc_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PER_PHASE   = 163;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  class hue_scoreboard;
    localparam logic [7:0]  FULL_V    = 8'd127;
    localparam logic [7:0]  FLOOR_P   = 8'd25;
    localparam logic [31:0] Q_ORIGIN  = 32'd8355840;
    localparam logic [31:0] T_ORIGIN  = 32'd1671168;
    localparam logic [31:0] FRAC_GAIN = 32'd102;

    logic [15:0] min_lvl;
    logic [15:0] max_lvl;
    color_t      colors_due[$];
    int          mismatches;
    int          pixels;
    int          range_writes;

    function new();
      min_lvl = 16'd0;
      max_lvl = 16'd65535;
      mismatches = 0;
      pixels = 0;
      range_writes = 0;
    endfunction

    function void report(string msg);
      if (mismatches < 30) $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void set_range(cfg_reg_t idx, logic [15:0] val);
      range_writes++;
      if (idx == REG_MIN_LEVEL) min_lvl = val;
      else if (idx == REG_MAX_LEVEL) max_lvl = val;
    endfunction

    function int pending();
      return colors_due.size();
    endfunction

    // Work out the color for one accepted pixel level.
    function void note_pixel(logic [15:0] lvl);
      logic [15:0] x;
      logic [63:0] hue;
      sector_t     sec;
      logic [31:0] frac;
      logic [31:0] q_sum;
      logic [31:0] t_sum;
      color_t      c;
      pixels++;
      if (max_lvl <= min_lvl) begin
        hue = 64'd0;
      end else begin
        x = lvl;
        if (x < min_lvl) x = min_lvl;
        if (x > max_lvl) x = max_lvl;
        hue = (64'(x - min_lvl) << 18) / 64'(max_lvl - min_lvl);
      end
      sec = sector_t'(hue[18:16]);
      frac = 32'(hue[15:0]);
      q_sum = Q_ORIGIN - FRAC_GAIN * frac;
      t_sum = T_ORIGIN + FRAC_GAIN * frac;
      case (sec)
        SEC_RED_YELLOW: c = '{FULL_V, t_sum[23:16], FLOOR_P};
        SEC_YELLOW_GRN: c = '{q_sum[23:16], FULL_V, FLOOR_P};
        SEC_GRN_CYAN:   c = '{FLOOR_P, FULL_V, t_sum[23:16]};
        SEC_CYAN_BLUE:  c = '{FLOOR_P, q_sum[23:16], FULL_V};
        default:        c = '{t_sum[23:16], FLOOR_P, FULL_V};
      endcase
      colors_due.push_back(c);
    endfunction

    function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      color_t want;
      if (colors_due.size() == 0) begin
        report($sformatf("color word %0d/%0d/%0d with nothing expected", r, g, b));
        return;
      end
      want = colors_due.pop_front();
      if (r !== want.r) report($sformatf("red %0d, expected %0d", r, want.r));
      if (g !== want.g) report($sformatf("green %0d, expected %0d", g, want.g));
      if (b !== want.b) report($sformatf("blue %0d, expected %0d", b, want.b));
    endfunction

    function void close();
      if (colors_due.size() != 0)
        report($sformatf("%0d color words never arrived", colors_due.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_MIN_LEVEL;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] pixel_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  hue_scoreboard sb;
  int send_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  level_to_hsv_false_color uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_level(pixel_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stall, or a long hold when the stimulus asks for one.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_we) sb.set_range(cfg_index, cfg_data);
    if (!rst && in_valid && !in_stall) sb.note_pixel(pixel_level);
    if (!rst && out_valid && !out_stall) sb.check_color(red, green, blue);
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) stuck_cycles = 0;
    else stuck_cycles = stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task send_pixel(input logic [15:0] lvl);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid <= 1'b1;
    pixel_level <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every expected color has come out.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task apply_range(input logic [15:0] lo, input logic [15:0] hi);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_LEVEL;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_LEVEL;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function logic [15:0] pick_level(logic [15:0] lo, logic [15:0] hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20 || hi <= lo) return 16'($urandom_range(65535));
    if (roll < 25) return lo;
    if (roll < 30) return hi;
    return 16'($urandom_range(hi, lo));
  endfunction

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] plan[$];
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full range ends, exact sector boundaries, clamping, empty
    // and inverted ranges.
    plan = '{16'd0, 16'd65535, 16'd1, 16'd65534, 16'h5555, 16'hAAAA, 16'd32768};
    foreach (plan[i]) send_pixel(plan[i]);
    apply_range(16'd100, 16'd104);
    plan = '{16'd98, 16'd100, 16'd101, 16'd102, 16'd103, 16'd104, 16'd105, 16'd65535};
    foreach (plan[i]) send_pixel(plan[i]);
    apply_range(16'd500, 16'd500);
    plan = '{16'd0, 16'd500, 16'd65535};
    foreach (plan[i]) send_pixel(plan[i]);
    apply_range(16'd60000, 16'd10);
    plan = '{16'd5, 16'd30000, 16'd65535};
    foreach (plan[i]) send_pixel(plan[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lo = 16'd0; hi = 16'd65535; end
        1: begin
          lo = 16'($urandom_range(65235));
          hi = lo + 16'($urandom_range(300, 1));
        end
        2: begin lo = 16'd0; hi = 16'd1; end
        3: begin lo = 16'd65534; hi = 16'd65535; end
        5: begin lo = 16'($urandom_range(65535)); hi = lo; end
        6: begin lo = 16'd65535; hi = 16'd0; end
        8: begin lo = 16'd0; hi = 16'd4; end
        default: begin
          lo = 16'($urandom_range(65535));
          hi = 16'($urandom_range(65535));
        end
      endcase
      apply_range(lo, hi);
      case (ph % 4)
        0: begin send_pct = 0; stall_pct = 0; end
        1: begin send_pct = 46; stall_pct = 0; end
        2: begin send_pct = 0; stall_pct = 46; end
        default: begin send_pct = 14; stall_pct = 14; end
      endcase
      for (int n = 0; n < PER_PHASE; n++) begin
        // Hold the receiver off while words keep coming so the pipe backs up.
        if ((ph == 0 || ph == 8) && n == 50) hold_asked = hold_asked + 1;
        if (ph == 6 && n == 80) drain();
        send_pixel(pick_level(lo, hi));
      end
    end

    drain();
    repeat (30) @(posedge clk);
    sb.close();
    $display("Covered %0d pixels over %0d range register writes, %0d long output holds,",
             sb.pixels, sb.range_writes, hold_asked);
    $display("with clamped, empty and inverted ranges under sender and receiver idling.");
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
design/lhfc_pkg.sv
design/lhfc_div.sv
design/level_to_hsv_false_color.sv
design/lhfc_checker.sv
tb/sv/tb_level_to_hsv_false_color.sv
